// ===== hw/rtl/rmp_pkg.sv =====
package rmp_pkg;

   // Frame geometry and pixel width
   localparam int MAX_ROWS   = 64;
   localparam int MAX_COLS   = 64;
   localparam int VALUE_BITS = 16;

   localparam int DEPTH  = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ROWN_W = $clog2(MAX_ROWS + 1);
   localparam int COLN_W = $clog2(MAX_COLS + 1);

   // Fixed field and register widths
   localparam int PIX_IN_W = 16;
   localparam int SIZE_W   = 7;
   localparam int CSR_AW   = 4;
   localparam int CSR_DW   = 32;

   // Register indexes
   localparam logic [1:0] REG_ROWS   = 2'd0;
   localparam logic [1:0] REG_COLS   = 2'd1;
   localparam logic [1:0] REG_SIGNED = 2'd2;

   // Request operations
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_FETCH = 1'b1;

   // Pixel labels
   typedef enum logic [1:0] {
      LBL_NOT   = 2'd0,
      LBL_MAYBE = 2'd1,
      LBL_MAX   = 2'd2
   } label_type;

   typedef logic [VALUE_BITS-1:0] pixel_type;

   // Control between top level and marking sequencer
   typedef struct packed {
      logic              start;
      logic [ROWN_W-1:0] rows;
      logic [COLN_W-1:0] cols;
      logic              signed_values;
   } mark_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mark_sts_type;

   // Unsigned key that orders like the selected signedness
   function automatic pixel_type order_key(input pixel_type v, input logic is_signed);
      pixel_type k;
      k = v;
      if (is_signed) begin
         k[VALUE_BITS-1] = ~v[VALUE_BITS-1];
      end
      return k;
   endfunction

   function automatic logic [ROWN_W-1:0] clamp_rows(input logic [SIZE_W-1:0] n);
      logic [ROWN_W-1:0] r;
      if (n == '0) begin
         r = ROWN_W'(1);
      end else if (32'(n) > MAX_ROWS) begin
         r = ROWN_W'(MAX_ROWS);
      end else begin
         r = ROWN_W'(n);
      end
      return r;
   endfunction

   function automatic logic [COLN_W-1:0] clamp_cols(input logic [SIZE_W-1:0] n);
      logic [COLN_W-1:0] r;
      if (n == '0) begin
         r = COLN_W'(1);
      end else if (32'(n) > MAX_COLS) begin
         r = COLN_W'(MAX_COLS);
      end else begin
         r = COLN_W'(n);
      end
      return r;
   endfunction

   // Neighbor offsets, index 0..7 clockwise from upper left
   function automatic logic signed [1:0] nbr_dr(input logic [2:0] k);
      logic signed [1:0] d;
      case (k)
         3'd0, 3'd1, 3'd2: d = -2'sd1;
         3'd3, 3'd7:       d = 2'sd0;
         default:          d = 2'sd1;
      endcase
      return d;
   endfunction

   function automatic logic signed [1:0] nbr_dc(input logic [2:0] k);
      logic signed [1:0] d;
      case (k)
         3'd0, 3'd7, 3'd6: d = -2'sd1;
         3'd1, 3'd5:       d = 2'sd0;
         default:          d = 2'sd1;
      endcase
      return d;
   endfunction

endpackage

// ===== hw/rtl/rmp_channels_if.sv =====
interface rmp_req_if;
   logic                        valid;
   logic                        ready;
   logic                        operation;
   logic [rmp_pkg::PIX_IN_W-1:0] pixel_value;

   modport source (output valid, output operation, output pixel_value, input ready);
   modport sink   (input valid, input operation, input pixel_value, output ready);
endinterface

interface rmp_rsp_if;
   logic valid;
   logic ready;
   logic is_max;
   logic last_flag;
   logic no_data;

   modport source (output valid, output is_max, output last_flag, output no_data, input ready);
   modport sink   (input valid, input is_max, input last_flag, input no_data, output ready);
endinterface

// ===== hw/rtl/rmp_ram.sv =====
module rmp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/rmp_marker.sv =====
module rmp_marker (
   input  logic                          clock,
   input  logic                          reset,
   input  rmp_pkg::mark_ctl_type         ctl,
   output rmp_pkg::mark_sts_type         sts,
   output logic [rmp_pkg::ADDR_W-1:0]    rd_addr,
   input  rmp_pkg::pixel_type            pix_rdata,
   input  logic [1:0]                    lbl_rdata,
   output logic                          lbl_we,
   output logic [rmp_pkg::ADDR_W-1:0]    lbl_waddr,
   output logic [1:0]                    lbl_wdata
);
   import rmp_pkg::*;

   typedef enum logic [1:0] {M_IDLE, M_INIT, M_RELAX} state_type;

   // Each pixel takes ten steps: center read, eight neighbor reads, last compare
   localparam logic [3:0] STEP_LAST = 4'd9;

   state_type         state_ff, state_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [3:0]        step_ff, step_in;
   logic              inb_ff, inb_in;
   pixel_type         me_ff, me_in;
   logic              gt_ff, gt_in, eq_ff, eq_in, drop_ff, drop_in;
   logic              maybe_ff, maybe_in;
   logic              changed_ff, changed_in;
   logic              done_ff, done_in;
   logic [ROWN_W-1:0] rows_ff;
   logic [COLN_W-1:0] cols_ff;
   logic              sgn_ff;

   logic signed [ROW_W+1:0] nr;
   logic signed [COL_W+1:0] nc;
   logic [2:0]              nk;
   logic                    inb_req;
   pixel_type               key;
   logic                    hit_gt, hit_eq, hit_drop;
   logic                    last_col, last_row;
   logic [ADDR_W-1:0]       cur_addr;

   // Address of the step's read: center on step 0, neighbor otherwise
   always_comb begin
      nk = 3'(step_ff - 4'd1);
      if (step_ff == '0) begin
         nr = (ROW_W+2)'(row_ff);
         nc = (COL_W+2)'(col_ff);
      end else begin
         nr = $signed((ROW_W+2)'(row_ff)) + (ROW_W+2)'(nbr_dr(nk));
         nc = $signed((COL_W+2)'(col_ff)) + (COL_W+2)'(nbr_dc(nk));
      end
      inb_req = (nr >= 0) && (nc >= 0) &&
                (nr < $signed((ROW_W+2)'(rows_ff))) && (nc < $signed((COL_W+2)'(cols_ff)));
      rd_addr  = ADDR_W'(nr[ROW_W-1:0] * cols_ff + (ADDR_W)'(nc[COL_W-1:0]));
      cur_addr = ADDR_W'(row_ff * cols_ff + (ADDR_W)'(col_ff));
   end

   // Compare the returned neighbor against the center
   always_comb begin
      key      = order_key(pix_rdata, sgn_ff);
      hit_gt   = inb_ff && (step_ff >= 4'd2) && (key > me_ff);
      hit_eq   = inb_ff && (step_ff >= 4'd2) && (key == me_ff);
      hit_drop = hit_eq && (lbl_rdata == LBL_NOT);
      last_col = (COLN_W'(col_ff) == cols_ff - COLN_W'(1));
      last_row = (ROWN_W'(row_ff) == rows_ff - ROWN_W'(1));
   end

   always_comb begin
      state_in   = state_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      step_in    = step_ff;
      inb_in     = inb_req;
      me_in      = me_ff;
      gt_in      = gt_ff | hit_gt;
      eq_in      = eq_ff | hit_eq;
      drop_in    = drop_ff | hit_drop;
      maybe_in   = maybe_ff;
      changed_in = changed_ff;
      done_in    = 1'b0;
      lbl_we     = 1'b0;
      lbl_waddr  = cur_addr;
      lbl_wdata  = LBL_NOT;

      if (step_ff == 4'd1) begin
         me_in    = key;
         maybe_in = (lbl_rdata == LBL_MAYBE);
         gt_in    = 1'b0;
         eq_in    = 1'b0;
         drop_in  = 1'b0;
      end

      unique case (state_ff)
         M_IDLE: begin
            if (ctl.start) begin
               state_in   = M_INIT;
               row_in     = '0;
               col_in     = '0;
               step_in    = '0;
               changed_in = 1'b0;
            end
         end
         M_INIT, M_RELAX: begin
            step_in = step_ff + 4'd1;
            if (step_ff == STEP_LAST) begin
               step_in = '0;
               // Label write-back for this pixel
               if (state_ff == M_INIT) begin
                  lbl_we    = 1'b1;
                  lbl_wdata = gt_in ? LBL_NOT : (eq_in ? LBL_MAYBE : LBL_MAX);
               end else if (maybe_ff && drop_in) begin
                  lbl_we     = 1'b1;
                  lbl_wdata  = LBL_NOT;
                  changed_in = 1'b1;
               end
               // Raster advance and pass control
               if (!last_col) begin
                  col_in = col_ff + COL_W'(1);
               end else begin
                  col_in = '0;
                  row_in = row_ff + ROW_W'(1);
                  if (last_row) begin
                     row_in = '0;
                     if (state_ff == M_INIT || changed_in) begin
                        state_in = M_RELAX;
                     end else begin
                        state_in = M_IDLE;
                        done_in  = 1'b1;
                     end
                     changed_in = 1'b0;
                  end
               end
            end
         end
         default: state_in = M_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= M_IDLE;
         step_ff    <= '0;
         done_ff    <= 1'b0;
         changed_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         step_ff    <= step_in;
         done_ff    <= done_in;
         changed_ff <= changed_in;
      end
      row_ff   <= row_in;
      col_ff   <= col_in;
      inb_ff   <= inb_in;
      me_ff    <= me_in;
      gt_ff    <= gt_in;
      eq_ff    <= eq_in;
      drop_ff  <= drop_in;
      maybe_ff <= maybe_in;
      if (ctl.start) begin
         rows_ff <= ctl.rows;
         cols_ff <= ctl.cols;
         sgn_ff  <= ctl.signed_values;
      end
   end

   assign sts.busy = (state_ff != M_IDLE);
   assign sts.done = done_ff;

endmodule

// ===== hw/rtl/regional_max_plateau_8conn_unit.sv =====
// Channel  Dir  Handshake      Payload
// req      in   valid/ready    operation, pixel_value
// rsp      out  valid/ready    is_max, last_flag, no_data
// csr      in   APB write/read row_count, col_count, signed_values
//
// The load that completes the frame starts marking. Marking reads each pixel and
// its eight neighbors through the one pixel-memory port, then compares, in one
// initial pass and then relaxation passes until no label changes. A fetch with
// flags ready goes through the registered label-memory read; one without them
// answers no_data. Requests stall while marking runs, during a fetch and while
// a result waits on rsp. Reset is synchronous; the memories are not cleared.
module regional_max_plateau_8conn_unit (
   input  logic                         clock,
   input  logic                         reset,
   rmp_req_if.sink                      req_chan,
   rmp_rsp_if.source                    rsp_chan,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [rmp_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [rmp_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [rmp_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                         csr_pready
);
   import rmp_pkg::*;

   typedef enum logic [1:0] {T_IDLE, T_MARK, T_FETCH} state_type;

   state_type         state_ff, state_in;
   logic [SIZE_W-1:0] row_count_ff, col_count_ff;
   logic              signed_ff;
   logic [ADDR_W-1:0] load_ptr_ff, load_ptr_in;
   logic [CNT_W-1:0]  read_ptr_ff, read_ptr_in;
   logic              flags_ready_ff, flags_ready_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              is_max_ff, is_max_in, last_ff, last_in, no_data_ff, no_data_in;

   logic [ROWN_W-1:0] rows;
   logic [COLN_W-1:0] cols;
   logic [CNT_W-1:0]  total;
   logic              accept, cfg_we;
   logic [1:0]        cfg_idx;

   mark_ctl_type      mctl;
   mark_sts_type      msts;
   logic [ADDR_W-1:0] mark_rd_addr, lbl_rd_addr, lbl_waddr;
   pixel_type         pix_rdata;
   logic [1:0]        lbl_rdata, lbl_wdata;
   logic              lbl_we, pix_we;

   assign rows  = clamp_rows(row_count_ff);
   assign cols  = clamp_cols(col_count_ff);
   assign total = CNT_W'(rows * cols);

   // Configuration port
   assign csr_pready = 1'b1;
   assign cfg_idx    = csr_paddr[3:2];
   assign cfg_we     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      unique case (cfg_idx)
         REG_ROWS:   csr_prdata = CSR_DW'(row_count_ff);
         REG_COLS:   csr_prdata = CSR_DW'(col_count_ff);
         REG_SIGNED: csr_prdata = CSR_DW'(signed_ff);
         default:    csr_prdata = '0;
      endcase
   end

   assign req_chan.ready = (state_ff == T_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;
   assign pix_we         = accept && (req_chan.operation == OP_LOAD);

   // Request sequencing
   always_comb begin
      state_in           = state_ff;
      load_ptr_in        = load_ptr_ff;
      read_ptr_in        = read_ptr_ff;
      flags_ready_in     = flags_ready_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_chan.ready;
      is_max_in          = is_max_ff;
      last_in            = last_ff;
      no_data_in         = no_data_ff;
      mctl.start         = 1'b0;
      mctl.rows          = rows;
      mctl.cols          = cols;
      mctl.signed_values = signed_ff;

      unique case (state_ff)
         T_IDLE: begin
            if (accept && req_chan.operation == OP_LOAD) begin
               if (flags_ready_ff) begin
                  flags_ready_in = 1'b0;
                  read_ptr_in    = '0;
               end
               load_ptr_in = load_ptr_ff + ADDR_W'(1);
               if (CNT_W'(load_ptr_ff) + CNT_W'(1) == total) begin
                  load_ptr_in = '0;
                  mctl.start  = 1'b1;
                  state_in    = T_MARK;
               end
            end else if (accept) begin
               if (!flags_ready_ff) begin
                  rsp_valid_in = 1'b1;
                  is_max_in    = 1'b0;
                  last_in      = 1'b0;
                  no_data_in   = 1'b1;
               end else begin
                  state_in = T_FETCH;
               end
            end
         end
         T_MARK: begin
            if (msts.done) begin
               flags_ready_in = 1'b1;
               read_ptr_in    = '0;
               state_in       = T_IDLE;
            end
         end
         T_FETCH: begin
            rsp_valid_in = 1'b1;
            is_max_in    = (lbl_rdata != LBL_NOT);
            last_in      = (read_ptr_ff + CNT_W'(1) == total);
            no_data_in   = 1'b0;
            read_ptr_in  = read_ptr_ff + CNT_W'(1);
            if (last_in) begin
               read_ptr_in    = '0;
               flags_ready_in = 1'b0;
            end
            state_in = T_IDLE;
         end
         default: state_in = T_IDLE;
      endcase

      // Any register write restarts the frame
      if (cfg_we && (cfg_idx == REG_ROWS || cfg_idx == REG_COLS || cfg_idx == REG_SIGNED))
      begin
         load_ptr_in    = '0;
         read_ptr_in    = '0;
         flags_ready_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= T_IDLE;
         row_count_ff   <= SIZE_W'(64);
         col_count_ff   <= SIZE_W'(64);
         signed_ff      <= 1'b0;
         load_ptr_ff    <= '0;
         read_ptr_ff    <= '0;
         flags_ready_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         load_ptr_ff    <= load_ptr_in;
         read_ptr_ff    <= read_ptr_in;
         flags_ready_ff <= flags_ready_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (cfg_we) begin
            unique case (cfg_idx)
               REG_ROWS:   row_count_ff <= csr_pwdata[SIZE_W-1:0];
               REG_COLS:   col_count_ff <= csr_pwdata[SIZE_W-1:0];
               REG_SIGNED: signed_ff    <= csr_pwdata[0];
               default:    ;
            endcase
         end
      end
      is_max_ff  <= is_max_in;
      last_ff    <= last_in;
      no_data_ff <= no_data_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.is_max    = is_max_ff;
   assign rsp_chan.last_flag = last_ff;
   assign rsp_chan.no_data   = no_data_ff;

   // Marking sequencer and stores
   assign lbl_rd_addr = (state_ff == T_MARK) ? mark_rd_addr : read_ptr_ff[ADDR_W-1:0];

   rmp_marker u_marker (
      .clock     (clock),
      .reset     (reset),
      .ctl       (mctl),
      .sts       (msts),
      .rd_addr   (mark_rd_addr),
      .pix_rdata (pix_rdata),
      .lbl_rdata (lbl_rdata),
      .lbl_we    (lbl_we),
      .lbl_waddr (lbl_waddr),
      .lbl_wdata (lbl_wdata)
   );

   rmp_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_pixel_ram (
      .clock   (clock),
      .wr_en   (pix_we),
      .wr_addr (load_ptr_ff),
      .wr_data (VALUE_BITS'(req_chan.pixel_value)),
      .rd_addr (mark_rd_addr),
      .rd_data (pix_rdata)
   );

   rmp_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_label_ram (
      .clock   (clock),
      .wr_en   (lbl_we),
      .wr_addr (lbl_waddr),
      .wr_data (lbl_wdata),
      .rd_addr (lbl_rd_addr),
      .rd_data (lbl_rdata)
   );

endmodule

// ===== hw/rtl/rmp_checker.sv =====
module rmp_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_operation,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_is_max,
   input logic rsp_last_flag,
   input logic rsp_no_data
);
   import rmp_pkg::*;

   // A waiting result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp dropped before taken");

   // Nothing is offered right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // A load never yields a result
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_operation == OP_LOAD && (!rsp_valid || rsp_ready)
      |=> !rsp_valid)
      else $error("result after a load request");

   // An empty fetch carries no flag
   a_no_data_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_data |-> !rsp_is_max && !rsp_last_flag)
      else $error("no_data with flag bits set");

endmodule

bind regional_max_plateau_8conn_unit rmp_checker u_rmp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .req_operation (req_chan.operation),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_is_max    (rsp_chan.is_max),
   .rsp_last_flag (rsp_chan.last_flag),
   .rsp_no_data   (rsp_chan.no_data)
);

// ===== tb/regional_max_plateau_8conn_unit_tb.sv =====
module regional_max_plateau_8conn_unit_tb;
   import rmp_pkg::*;

   localparam int CYCLE_LIMIT   = 3000000;
   localparam int RANDOM_ITEMS  = 1550;

   // One fetch result as seen on rsp
   typedef struct packed {
      logic is_max;
      logic last_flag;
      logic no_data;
   } flag_rec_type;

   // Regional maxima predictor and the store of flags still to come
   class max_flag_scoreboard;
      logic [15:0]  pix_mem [DEPTH];
      label_type    lbl_mem [DEPTH];
      int unsigned  load_ptr;
      int unsigned  read_ptr;
      bit           flags_rdy;
      int unsigned  rows_reg;
      int unsigned  cols_reg;
      bit           sgn;
      flag_rec_type flag_q[$];
      int           fails;
      int           settle;

      function new();
         load_ptr  = 0;
         read_ptr  = 0;
         flags_rdy = 0;
         rows_reg  = 64;
         cols_reg  = 64;
         sgn       = 0;
         fails     = 0;
         settle    = 0;
      endfunction

      function int unsigned rows_eff();
         return (rows_reg == 0) ? 1 : (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
      endfunction

      function int unsigned cols_eff();
         return (cols_reg == 0) ? 1 : (cols_reg > MAX_COLS) ? MAX_COLS : cols_reg;
      endfunction

      function logic [15:0] rank_of(logic [15:0] v);
         return sgn ? (v ^ 16'h8000) : v;
      endfunction

      // any register write restarts the frame
      function void write_csr(logic [1:0] idx, logic [31:0] val);
         if (idx == REG_ROWS) rows_reg = val[6:0];
         else if (idx == REG_COLS) cols_reg = val[6:0];
         else if (idx == REG_SIGNED) sgn = val[0];
         load_ptr  = 0;
         read_ptr  = 0;
         flags_rdy = 0;
      endfunction

      // initial labeling, then relaxation until stable
      function void mark_frame();
         int rows, cols, nr, nc, passes;
         bit greater, equal, drop, changed;
         logic [15:0] me, nv;
         rows = rows_eff();
         cols = cols_eff();
         for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < cols; c++) begin
               me = rank_of(pix_mem[r*cols+c]);
               greater = 0;
               equal = 0;
               for (int dr = -1; dr <= 1; dr++) begin
                  for (int dc = -1; dc <= 1; dc++) begin
                     nr = r + dr;
                     nc = c + dc;
                     if ((dr == 0 && dc == 0) || nr < 0 || nc < 0 || nr >= rows || nc >= cols)
                        continue;
                     nv = rank_of(pix_mem[nr*cols+nc]);
                     if (nv > me) greater = 1;
                     else if (nv == me) equal = 1;
                  end
               end
               lbl_mem[r*cols+c] = greater ? LBL_NOT : (equal ? LBL_MAYBE : LBL_MAX);
            end
         end
         passes = 0;
         do begin
            changed = 0;
            passes++;
            for (int r = 0; r < rows; r++) begin
               for (int c = 0; c < cols; c++) begin
                  if (lbl_mem[r*cols+c] != LBL_MAYBE) continue;
                  me = rank_of(pix_mem[r*cols+c]);
                  drop = 0;
                  for (int dr = -1; dr <= 1; dr++) begin
                     for (int dc = -1; dc <= 1; dc++) begin
                        nr = r + dr;
                        nc = c + dc;
                        if (nr < 0 || nc < 0 || nr >= rows || nc >= cols) continue;
                        if (rank_of(pix_mem[nr*cols+nc]) == me &&
                            lbl_mem[nr*cols+nc] == LBL_NOT)
                           drop = 1;
                     end
                  end
                  if (drop) begin
                     lbl_mem[r*cols+c] = LBL_NOT;
                     changed = 1;
                  end
               end
            end
         end while (changed);
         settle = 10 * rows * cols * (passes + 1) + 32;
      endfunction

      function void note_request(logic op, logic [15:0] v);
         int unsigned total;
         flag_rec_type f;
         total = rows_eff() * cols_eff();
         if (op == OP_LOAD) begin
            // a load drops whatever flags are still pending
            if (flags_rdy) begin
               flags_rdy = 0;
               read_ptr = 0;
            end
            if (load_ptr >= DEPTH) load_ptr = 0;
            pix_mem[load_ptr] = v;
            load_ptr++;
            if (load_ptr >= total) begin
               mark_frame();
               load_ptr = 0;
               read_ptr = 0;
               flags_rdy = 1;
            end
         end else begin
            if (!flags_rdy || read_ptr >= total) begin
               flags_rdy = 0;
               f = '{is_max: 1'b0, last_flag: 1'b0, no_data: 1'b1};
            end else begin
               f.is_max    = (lbl_mem[read_ptr] != LBL_NOT);
               f.last_flag = (read_ptr + 1 == total);
               f.no_data   = 1'b0;
               read_ptr++;
               if (read_ptr >= total) begin
                  flags_rdy = 0;
                  read_ptr = 0;
               end
            end
            flag_q.push_back(f);
         end
      endfunction

      function void check_response(flag_rec_type got);
         flag_rec_type want;
         if (flag_q.size() == 0) begin
            $error("unexpected response is_max=%0d last_flag=%0d no_data=%0d",
                   got.is_max, got.last_flag, got.no_data);
            fails++;
            return;
         end
         want = flag_q.pop_front();
         if (got.is_max !== want.is_max) begin
            $error("is_max expected %0d actual %0d", want.is_max, got.is_max);
            fails++;
         end
         if (got.last_flag !== want.last_flag) begin
            $error("last_flag expected %0d actual %0d", want.last_flag, got.last_flag);
            fails++;
         end
         if (got.no_data !== want.no_data) begin
            $error("no_data expected %0d actual %0d", want.no_data, got.no_data);
            fails++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic                csr_psel = 0;
   logic                csr_penable = 0;
   logic                csr_pwrite = 0;
   logic [CSR_AW-1:0]   csr_paddr = '0;
   logic [CSR_DW-1:0]   csr_pwdata = '0;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   rmp_req_if req_bus();
   rmp_rsp_if rsp_bus();

   max_flag_scoreboard flags_sb = new();
   int send_idle = 0;
   int recv_idle = 0;
   int random_count = 0;
   int cycles = 0;
   bit counting = 0;

   regional_max_plateau_8conn_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus.sink),
      .rsp_chan    (rsp_bus.source),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // clock, period 4
   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("regional_max_plateau_8conn_unit_tb NOT OK");
         $finish;
      end
   end

   // response side: random stalls, check on handshake
   initial rsp_bus.ready = 0;
   always @(negedge clock) rsp_bus.ready = ($urandom_range(99) >= recv_idle);

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         flags_sb.check_response('{rsp_bus.is_max, rsp_bus.last_flag, rsp_bus.no_data});
   end

   // drive one request, called and returning at a falling edge
   task automatic push_req(logic op, logic [15:0] v);
      while ($urandom_range(99) < send_idle) begin
         req_bus.valid = 0;
         @(negedge clock);
      end
      req_bus.valid       = 1;
      req_bus.operation   = op;
      req_bus.pixel_value = v;
      do @(posedge clock); while (!req_bus.ready);
      flags_sb.note_request(op, v);
      if (counting) random_count++;
      @(negedge clock);
   endtask

   // idle the request side until all flags are back and marking is over
   task automatic drain();
      req_bus.valid = 0;
      while (flags_sb.flag_q.size() > 0) @(negedge clock);
      repeat (flags_sb.settle) @(negedge clock);
   endtask

   // APB write, only while the block is idle
   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      drain();
      csr_psel    = 1;
      csr_penable = 0;
      csr_pwrite  = 1;
      csr_paddr   = CSR_AW'({idx, 2'b00});
      csr_pwdata  = val;
      @(negedge clock);
      csr_penable = 1;
      do @(posedge clock); while (!csr_pready);
      flags_sb.write_csr(idx, val);
      @(negedge clock);
      csr_psel    = 0;
      csr_penable = 0;
      csr_pwrite  = 0;
   endtask

   function automatic logic [15:0] pick_pixel(int mode, logic [15:0] base);
      case (mode)
         0:       return 16'($urandom_range(0, 65535));
         1:       return base + 16'($urandom_range(0, 2));
         default: return base + 16'($urandom_range(0, 1));
      endcase
   endfunction

   function automatic int pick_size();
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return 1;
         2:       return 64;
         3:       return 127;
         default: return $urandom_range(1, 6);
      endcase
   endfunction

   // new geometry and signedness, kept at 64 pixels or fewer
   task automatic reconfigure();
      int r, c, re, ce;
      r = pick_size();
      c = pick_size();
      re = (r == 0) ? 1 : (r > 64) ? 64 : r;
      ce = (c == 0) ? 1 : (c > 64) ? 64 : c;
      if (re * ce > 64) begin
         if ($urandom_range(0, 1)) c = $urandom_range(0, 1);
         else r = $urandom_range(0, 1);
      end
      write_reg(REG_ROWS, r);
      write_reg(REG_COLS, c);
      write_reg(REG_SIGNED, $urandom_range(0, 1));
   endtask

   // one frame: loads with random content and stray fetches, then fetches, sometimes broken off
   task automatic run_frame();
      int total, mode, nfetch;
      logic [15:0] base;
      total = flags_sb.rows_eff() * flags_sb.cols_eff();
      mode = $urandom_range(0, 2);
      case ($urandom_range(0, 4))
         0:       base = 16'h0000;
         1:       base = 16'h7FFE;
         2:       base = 16'h8000;
         3:       base = 16'hFFFD;
         default: base = 16'($urandom_range(0, 65535));
      endcase
      for (int i = 0; i < total; i++) begin
         if ($urandom_range(0, 39) == 0) push_req(OP_FETCH, 16'($urandom));
         push_req(OP_LOAD, pick_pixel(mode, base));
      end
      if ($urandom_range(0, 9) == 0) nfetch = $urandom_range(0, total - 1);
      else nfetch = total + (($urandom_range(0, 5) == 0) ? 1 : 0);
      for (int i = 0; i < nfetch; i++) push_req(OP_FETCH, 16'($urandom));
   endtask

   initial begin
      bit paused;
      req_bus.valid = 0;
      req_bus.operation = OP_LOAD;
      req_bus.pixel_value = '0;
      repeat (11) @(negedge clock);
      reset = 0;

      // directed: signed 1x3 with extreme values, plus a fetch past the end
      write_reg(REG_SIGNED, 1);
      write_reg(REG_ROWS, 1);
      write_reg(REG_COLS, 3);
      push_req(OP_LOAD, 16'h7FFF);
      push_req(OP_LOAD, 16'h8000);
      push_req(OP_LOAD, 16'h7FFF);
      repeat (4) push_req(OP_FETCH, 16'hFFFF);
      // unsigned 2x2 plateau, broken off by a load of the next frame
      write_reg(REG_SIGNED, 0);
      write_reg(REG_ROWS, 2);
      write_reg(REG_COLS, 2);
      push_req(OP_LOAD, 16'hFFFF);
      push_req(OP_LOAD, 16'h0000);
      push_req(OP_LOAD, 16'hFFFF);
      push_req(OP_LOAD, 16'hFFFF);
      repeat (2) push_req(OP_FETCH, 16'h0000);
      push_req(OP_LOAD, 16'h0000);
      push_req(OP_FETCH, 16'h0000);
      push_req(OP_LOAD, 16'h0005);
      push_req(OP_LOAD, 16'h0005);
      push_req(OP_LOAD, 16'h0004);
      repeat (4) push_req(OP_FETCH, 16'h0000);

      // random frames in three idling phases
      counting = 1;
      paused = 0;
      while (random_count < RANDOM_ITEMS) begin
         if (random_count < RANDOM_ITEMS / 3) begin
            send_idle = 21;
            recv_idle = 85;
         end else if (random_count < 2 * RANDOM_ITEMS / 3) begin
            send_idle = 85;
            recv_idle = 21;
            if (!paused) begin
               drain();
               paused = 1;
            end
         end else begin
            send_idle = 0;
            recv_idle = 0;
         end
         if ($urandom_range(0, 2) == 0) reconfigure();
         run_frame();
      end

      drain();
      repeat (50) @(negedge clock);
      if (flags_sb.fails == 0 && flags_sb.flag_q.size() == 0) begin
         $display("regional_max_plateau_8conn_unit_tb OK");
      end else begin
         $display("regional_max_plateau_8conn_unit_tb NOT OK");
      end
      $finish;
   end

endmodule
